>>> sv/mmcp_pkg.sv
// ----------------------------------------------------------------------------
// mmcp_pkg
// Shared types and codes for the contiguous partition search block.
// ----------------------------------------------------------------------------
package mmcp_pkg;

	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned LIMIT_W  = 26;
	localparam int unsigned PARTS_W  = 11;

	localparam logic STATUS_OK             = 1'b0;
	localparam logic STATUS_TOO_MANY_PARTS = 1'b1;

	typedef struct packed {
		logic [WEIGHT_W-1:0] item_weight;
		logic                last_item;
	} item_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] best_limit;
		logic               status;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic item_accept;
		logic search_init;
		logic mid_load;
		logic pass_init;
		logic rd_en;
		logic decide;
		logic res_load;
		logic res_err;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic too_many_parts;
		logic search_open;
		logic rd_last;
		logic fit;
		logic mid_zero;
	} stat_t;

endpackage

>>> sv/mmcp_dp.sv
// ----------------------------------------------------------------------------
// mmcp_dp
// Datapath: item store, totals, binary search bounds, greedy checker and
// result register.
// ----------------------------------------------------------------------------
module mmcp_dp #(
	parameter int unsigned MAX_ITEMS   = 1024,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mmcp_pkg::WEIGHT_W-1:0]    item_weight,
	input  logic                             cfg_we,
	input  logic [mmcp_pkg::PARTS_W-1:0]     cfg_wdata,
	input  mmcp_pkg::cmd_t                   cmd,
	output mmcp_pkg::stat_t                  stat,
	output mmcp_pkg::result_t                result
);
	import mmcp_pkg::*;

	localparam int unsigned SW    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int unsigned AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned TW    = CNT_W + SW;
	localparam int unsigned XW    = (TW > LIMIT_W) ? TW : LIMIT_W;
	localparam int unsigned PW    = (CNT_W > PARTS_W) ? CNT_W : PARTS_W;

	logic [SW-1:0]      mem [MAX_ITEMS];
	logic [SW-1:0]      rdata_s1;
	logic               vld_s1;
	logic [AW-1:0]      rd_idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [TW-1:0]      total_q;
	logic [TW-1:0]      low_q;
	logic [TW-1:0]      high_q;
	logic [TW-1:0]      best_q;
	logic [TW-1:0]      mid_q;
	logic [TW-1:0]      running_q;
	logic [CNT_W-1:0]   used_q;
	logic               fail_q;
	logic [PARTS_W-1:0] part_count_q;
	logic [LIMIT_W-1:0] res_limit_q;
	logic               res_status_q;

	logic [SW-1:0]      w_in;
	logic               room;
	logic [PARTS_W-1:0] parts;
	logic [TW:0]        mid_sum;
	logic [TW:0]        run_sum;
	logic [TW-1:0]      w_rd;
	logic [XW-1:0]      best_x;

	assign w_in    = item_weight[SW-1:0];
	assign room    = count_q < CNT_W'(MAX_ITEMS);
	assign parts   = (part_count_q == '0) ? PARTS_W'(1) : part_count_q;
	assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
	assign w_rd    = TW'(rdata_s1);
	assign run_sum = {1'b0, running_q} + {1'b0, w_rd};
	assign best_x  = XW'(best_q);

	assign stat.too_many_parts = PW'(parts) > PW'(count_q);
	assign stat.search_open    = low_q <= high_q;
	assign stat.rd_last        = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;
	assign stat.fit            = !fail_q && (PW'(used_q) <= PW'(parts));
	assign stat.mid_zero       = mid_q == '0;

	assign result.best_limit = res_limit_q;
	assign result.status     = res_status_q;

	// item store
	always_ff @(posedge clk) begin
		if (cmd.item_accept && room) begin
			mem[count_q[AW-1:0]] <= w_in;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= PARTS_W'(1);
			count_q      <= '0;
			total_q      <= '0;
			vld_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				part_count_q <= cfg_wdata;
			end
			vld_s1 <= cmd.rd_en;
			if (cmd.res_load) begin
				count_q <= '0;
				total_q <= '0;
			end else if (cmd.item_accept && room) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= total_q + TW'(w_in);
			end
		end
	end

	// search bounds, greedy pass and result
	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			low_q  <= '0;
			high_q <= total_q;
			best_q <= total_q;
		end
		if (cmd.mid_load) begin
			mid_q <= mid_sum[TW:1];
		end
		if (cmd.pass_init) begin
			rd_idx_q  <= '0;
			running_q <= '0;
			used_q    <= CNT_W'(1);
			fail_q    <= 1'b0;
		end else if (cmd.rd_en) begin
			rd_idx_q <= rd_idx_q + AW'(1);
		end
		if (vld_s1 && !cmd.pass_init) begin
			if (w_rd > mid_q) begin
				fail_q <= 1'b1;
			end else if (run_sum <= {1'b0, mid_q}) begin
				running_q <= run_sum[TW-1:0];
			end else begin
				used_q    <= used_q + CNT_W'(1);
				running_q <= w_rd;
			end
		end
		if (cmd.decide) begin
			if (stat.fit) begin
				best_q <= mid_q;
				if (mid_q != '0) begin
					high_q <= mid_q - TW'(1);
				end
			end else begin
				low_q <= mid_q + TW'(1);
			end
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_err ? STATUS_TOO_MANY_PARTS : STATUS_OK;
			res_limit_q  <= cmd.res_err ? '0 : best_x[LIMIT_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (CNT_W'(rd_idx_q) < count_q))
		else $error("read beyond loaded items");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !cmd.pass_init) |=> (fail_q || running_q <= mid_q))
		else $error("part total above probe limit");
	a_best_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && stat.fit) |=> (best_q == $past(mid_q)))
		else $error("best limit not taken from fitting probe");
`endif

endmodule

>>> sv/mmcp_ctrl.sv
// ----------------------------------------------------------------------------
// mmcp_ctrl
// Controller: load, bound check, probe passes and result hand-off.
// ----------------------------------------------------------------------------
module mmcp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_last,
	output logic            item_ready,
	input  logic            result_ready,
	output logic            result_valid,
	input  mmcp_pkg::stat_t stat,
	output mmcp_pkg::cmd_t  cmd
);
	import mmcp_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_PROBE,
		S_PASS,
		S_DRAIN,
		S_DECIDE,
		S_FINISH,
		S_REJECT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign item_ready   = state_q == S_LOAD;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				cmd.item_accept = item_valid;
				if (item_valid && item_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.too_many_parts) begin
					state_d = S_REJECT;
				end else begin
					cmd.search_init = 1'b1;
					state_d         = S_PROBE;
				end
			end
			S_PROBE: begin
				if (stat.search_open) begin
					cmd.mid_load  = 1'b1;
					cmd.pass_init = 1'b1;
					state_d       = S_PASS;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_PASS: begin
				cmd.rd_en = 1'b1;
				if (stat.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = (stat.fit && stat.mid_zero) ? S_FINISH : S_PROBE;
			end
			S_FINISH, S_REJECT: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_err  = state_q == S_REJECT;
					state_d      = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || result_ready))
		else $error("result overwritten before taken");
	a_load_vs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && cmd.rd_en))
		else $error("items taken during a probe pass");
	a_decide_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> $past(state_q == S_DRAIN))
		else $error("decision before pass drained");
`endif

endmodule

>>> sv/min_max_contiguous_partition.sv
// Order of work: items load, a check state follows, then up to log2(total)+2
// probes run, each a mid load, one store read per item, a drain and a decide.
// Throughput: one sequence at a time; the single read port of the item store
// sets the probe length. The result loads once the output register is free.
// Reset (arst_n low, asynchronous): the sequence is emptied, no result is
// pending and part_count returns to 1; the item store is left as it was.
// ----------------------------------------------------------------------------
// min_max_contiguous_partition
// Smallest maximum part total for a contiguous split of a weight sequence,
// found by binary search with a greedy check pass per probe.
// ----------------------------------------------------------------------------
module min_max_contiguous_partition #(
	parameter int unsigned MAX_ITEMS   = 1024,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  mmcp_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output mmcp_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic [mmcp_pkg::PARTS_W-1:0] cfg_wdata
);
	import mmcp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequence control: take items until the marked one, then run the probes
	// and hold the result in the output register until it is taken.
	mmcp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_last    (item.last_item),
		.item_ready   (item_ready),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.stat         (stat),
		.cmd          (cmd)
	);

	// Store, search bounds and greedy checker; the part count register lives
	// here as well, since the bound check and the checker read it.
	mmcp_dp #(
		.MAX_ITEMS   (MAX_ITEMS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_weight (item.item_weight),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.stat        (stat),
		.result      (result)
	);

endmodule

>>> test/mmcp_checker.sv
// ----------------------------------------------------------------------------
// mmcp_checker
// Watches the item, result and register ports of the partition block. Keeps
// its own copy of the loaded sequence, predicts the best limit for each marked
// item and compares every result taken against the oldest prediction.
// ----------------------------------------------------------------------------
module mmcp_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_ready,
	input  mmcp_pkg::item_t              item,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  mmcp_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic [mmcp_pkg::PARTS_W-1:0] cfg_wdata,
	output int                           pending,
	output int                           errors
);

	timeunit 1ns;
	timeprecision 1ps;

	import mmcp_pkg::*;

	localparam int STORE_DEPTH = 1024;

	logic [WEIGHT_W-1:0] weights [STORE_DEPTH];
	int                  seq_len;
	longint              seq_total;
	logic [PARTS_W-1:0]  part_setting;
	result_t             limit_q [$];

	// Greedy pass: open a new part whenever the next weight would overflow.
	function automatic bit fits_in_parts(longint cap, int parts);
		longint run;
		int     used;
		run  = 0;
		used = 1;
		for (int k = 0; k < seq_len; k++) begin
			if (weights[k] > cap)
				return 1'b0;
			if (run + weights[k] <= cap) begin
				run += weights[k];
			end else begin
				used++;
				run = weights[k];
			end
		end
		return used <= parts;
	endfunction

	function automatic result_t min_max_limit();
		result_t r;
		int      parts;
		longint  lo, hi, mid, best;
		parts = (part_setting == '0) ? 1 : int'(part_setting);
		if (parts > seq_len) begin
			r.best_limit = '0;
			r.status     = STATUS_TOO_MANY_PARTS;
			return r;
		end
		lo   = 0;
		hi   = seq_total;
		best = seq_total;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (fits_in_parts(mid, parts)) begin
				best = mid;
				if (mid == 0)
					break;
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		r.best_limit = best[LIMIT_W-1:0];
		r.status     = STATUS_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			seq_len      = 0;
			seq_total    = 0;
			part_setting = 1;
			limit_q.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			if (cfg_we)
				part_setting = cfg_wdata;
			if (item_valid && item_ready) begin
				// items past the store depth are dropped but a mark still ends
				if (seq_len < STORE_DEPTH) begin
					weights[seq_len] = item.item_weight;
					seq_len++;
					seq_total += item.item_weight;
				end
				if (item.last_item) begin
					limit_q.push_back(min_max_limit());
					seq_len   = 0;
					seq_total = 0;
				end
			end
			if (result_valid === 1'b1 && result_ready) begin
				if (limit_q.size() == 0) begin
					$display("%0t: unexpected result limit=%0d status=%0d", $time,
						result.best_limit, result.status);
					errors <= errors + 1;
				end else begin
					want = limit_q.pop_front();
					if (result.best_limit !== want.best_limit) begin
						$display("%0t: best_limit expected %0d actual %0d", $time,
							want.best_limit, result.best_limit);
						errors <= errors + 1;
					end else if (result.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, result.status);
						errors <= errors + 1;
					end
				end
			end
			pending <= limit_q.size();
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the contiguous partition search block. Directed
// sequences cover the weight extremes, the part count extremes and the
// overlong sequence; random phases then load mostly short sequences at varied
// part counts with random gaps on the item side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import mmcp_pkg::*;

	localparam int RANDOM_ITEMS = 550;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_CYCLES = 8;

	// weight styles for a whole sequence
	localparam int W_FULL    = 0;
	localparam int W_SMALL   = 1;
	localparam int W_EXTREME = 2;
	localparam int W_ZERO    = 3;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	item_t              item         = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	result_t            result;
	logic               cfg_we       = 1'b0;
	logic [PARTS_W-1:0] cfg_wdata    = '0;

	int pending;
	int errors;
	int cycle_count = 0;
	int ready_hold  = 0;
	int unsigned ready_pick;
	bit no_gaps = 1'b0;

	min_max_contiguous_partition u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	mmcp_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.pending      (pending),
		.errors       (errors)
	);

	always #6ns clk = ~clk;

	// Give up on a hung block: the limit counts every cycle of the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL min_max_contiguous_partition");
			$finish;
		end
	end

	// Result side back-pressure: hold ready steady for a random stretch, mostly
	// high with short drops, now and then a long stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_hold   <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 50) begin
				result_ready <= 1'b1;
				ready_hold   <= $urandom_range(0, 20);
			end else if (ready_pick < 90) begin
				result_ready <= 1'b0;
				ready_hold   <= $urandom_range(0, 3);
			end else begin
				result_ready <= 1'b0;
				ready_hold   <= $urandom_range(10, 60);
			end
		end
	end

	// Idle cycles before an item: none in quiet phases, otherwise mostly short.
	function automatic int gap_len();
		int unsigned p;
		if (no_gaps)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight(int style);
		case (style)
			W_SMALL:   return WEIGHT_W'($urandom_range(0, 15));
			W_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			W_ZERO:    return '0;
			default:   return WEIGHT_W'($urandom);
		endcase
	endfunction

	// Mostly short sequences keep the search passes brief.
	function automatic int pick_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 90)
			return $urandom_range(1, 12);
		if (p < 99)
			return $urandom_range(13, 64);
		return $urandom_range(100, 300);
	endfunction

	// Favour small part counts so most sequences search; keep zero and the
	// top of the range in the mix.
	function automatic logic [PARTS_W-1:0] pick_parts();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 10)
			return '0;
		if (p < 20)
			return PARTS_W'(1);
		if (p < 75)
			return PARTS_W'($urandom_range(2, 6));
		if (p < 85)
			return PARTS_W'($urandom_range(7, 40));
		if (p < 92)
			return PARTS_W'(1024);
		return '1;
	endfunction

	// Present one item after a random gap and hold it until accepted. Leave
	// valid high on return so a following item can go out back to back.
	task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic mark);
		item_t it;
		int    gap;
		it.item_weight = w;
		it.last_item   = mark;
		gap = gap_len();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic send_sequence(input int n, input int style);
		for (int i = 0; i < n; i++)
			send_item(pick_weight(style), i == n - 1);
	endtask

	// Drop valid, wait until every predicted result has been taken, then let
	// the block fall idle before anything else happens.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_parts(input logic [PARTS_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		int len;
		int nseq;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// part count still at its reset value of one
		send_item('0, 1'b1);
		send_item('1, 1'b1);

		// zero parts behaves as one part
		settle();
		set_parts('0);
		send_item('1, 1'b0);
		send_item('0, 1'b0);
		send_item('1, 1'b1);

		settle();
		set_parts(2);
		send_item(1, 1'b0);
		send_item(2, 1'b0);
		send_item(3, 1'b0);
		send_item(4, 1'b1);

		// more parts than items
		settle();
		set_parts(3);
		send_item(7, 1'b0);
		send_item(9, 1'b1);

		settle();
		set_parts('1);
		send_item(5, 1'b1);

		// overlong sequence at the widest useful part count: the tail beyond
		// the store depth is dropped, and the marked item still ends it
		settle();
		set_parts(1024);
		send_sequence(1030, W_FULL);

		// random phases: new part count, then a handful of sequences
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			no_gaps = ($urandom_range(0, 3) == 0);
			set_parts(pick_parts());
			nseq = $urandom_range(3, 8);
			repeat (nseq) begin
				len = pick_len();
				send_sequence(len, $urandom_range(W_FULL, W_ZERO));
				sent += len;
			end
		end

		settle();
		if (errors == 0 && pending == 0) begin
			$display("PASS min_max_contiguous_partition");
		end else begin
			$display("FAIL min_max_contiguous_partition");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/mmcp_pkg.sv
sv/mmcp_dp.sv
sv/mmcp_ctrl.sv
sv/min_max_contiguous_partition.sv
test/mmcp_checker.sv
test/tb_top.sv
